FILE: src/sdcb_pkg.sv
// Shared types, codes and constants of the SATA DMA command builder.
package sdcb_pkg;

  // Default sizes of the command table and the slot range.
  localparam int unsigned MaxEntriesDefault      = 8;
  localparam int unsigned SectorsPerEntryDefault = 16;
  localparam int unsigned SlotCountDefault       = 32;

  // Bytes in one sector and the reset value of the slot limit.
  localparam int unsigned SectorBytes     = 512;
  localparam logic [5:0]  SlotsInUseReset = 6'd32;

  // ATA opcodes placed in the host-to-device FIS.
  localparam logic [7:0] OpReadDmaExt  = 8'h25;
  localparam logic [7:0] OpWriteDmaExt = 8'h35;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_ENTRY     = 2'd0,
    KIND_COMMAND   = 2'd1,
    KIND_NO_SLOT   = 2'd2,
    KIND_BAD_COUNT = 2'd3
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  capture;
    logic  search;
    logic  split;
    logic  load;
    kind_e load_kind;
  } sdcb_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_found;
    logic count_bad;
    logic entries_done;
  } sdcb_status_t;

  // One result as held in the output register.
  typedef struct packed {
    kind_e        kind;
    logic [4:0]   slot;
    logic [63:0]  entry_address;
    logic [12:0]  entry_bytes_less_one;
    logic [3:0]   entry_total;
    logic [7:0]   ata_opcode;
    logic [47:0]  fis_block;
    logic [15:0]  fis_count;
    logic         direction_write;
    logic         last;
  } sdcb_res_t;

endpackage

FILE: src/sdcb_if.sv
// Request and result channel interfaces of the SATA DMA command builder.
interface sdcb_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [47:0] start_block;
  logic [15:0] sector_count;
  logic [63:0] buffer_address;
  logic [31:0] busy_slots;

  modport source (output valid, command, start_block, sector_count, buffer_address,
                  busy_slots, input ready);
  modport sink (input valid, command, start_block, sector_count, buffer_address,
                busy_slots, output ready);
endinterface

interface sdcb_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [4:0]  slot;
  logic [63:0] entry_address;
  logic [12:0] entry_bytes_less_one;
  logic [3:0]  entry_total;
  logic [7:0]  ata_opcode;
  logic [47:0] fis_block;
  logic [15:0] fis_count;
  logic        direction_write;
  logic        last;

  modport source (output valid, kind, slot, entry_address, entry_bytes_less_one,
                  entry_total, ata_opcode, fis_block, fis_count, direction_write, last,
                  input ready);
  modport sink (input valid, kind, slot, entry_address, entry_bytes_less_one,
                entry_total, ata_opcode, fis_block, fis_count, direction_write, last,
                output ready);
endinterface

FILE: src/sdcb_ctrl.sv
// Controller state machine: sequences capture, slot search, split and result output.
module sdcb_ctrl import sdcb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         req_valid_i,
  output logic         req_ready_o,
  input  logic         res_ready_i,
  output logic         res_valid_o,
  input  sdcb_status_t status_i,
  output sdcb_ctrl_t   ctrl_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SPLIT,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free    = !out_valid_q || res_ready_i;
  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = out_valid_q;

  // Next state and commands to the datapath.
  always_comb begin
    state_d          = state_q;
    out_valid_d      = out_valid_q && !res_ready_i;
    ctrl_o           = '0;
    ctrl_o.load_kind = KIND_ENTRY;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        ctrl_o.search = 1'b1;
        state_d       = ST_SPLIT;
      end
      ST_SPLIT: begin
        ctrl_o.split = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          ctrl_o.load = 1'b1;
          out_valid_d = 1'b1;
          if (!status_i.slot_found) begin
            ctrl_o.load_kind = KIND_NO_SLOT;
            state_d          = ST_IDLE;
          end else if (status_i.count_bad) begin
            ctrl_o.load_kind = KIND_BAD_COUNT;
            state_d          = ST_IDLE;
          end else if (!status_i.entries_done) begin
            ctrl_o.load_kind = KIND_ENTRY;
          end else begin
            ctrl_o.load_kind = KIND_COMMAND;
            state_d          = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: src/sdcb_datapath.sv
// Datapath: request registers, slot search, entry split and the output register.
module sdcb_datapath import sdcb_pkg::*; #(
  parameter int unsigned MAX_ENTRIES       = MaxEntriesDefault,
  parameter int unsigned SECTORS_PER_ENTRY = SectorsPerEntryDefault,
  parameter int unsigned SLOT_COUNT        = SlotCountDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_wr_en_i,
  input  logic [5:0]   cfg_wr_data_i,
  input  logic         command_i,
  input  logic [47:0]  start_block_i,
  input  logic [15:0]  sector_count_i,
  input  logic [63:0]  buffer_address_i,
  input  logic [31:0]  busy_slots_i,
  input  sdcb_ctrl_t   ctrl_i,
  output sdcb_status_t status_o,
  output sdcb_res_t    res_o
);

  localparam int unsigned NW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned RW = (SECTORS_PER_ENTRY > 1) ? $clog2(SECTORS_PER_ENTRY) : 1;
  // Reciprocal of the sectors per entry, exact for any 16-bit dividend.
  localparam logic [24:0] Recip = 25'((2**24 + SECTORS_PER_ENTRY - 1) / SECTORS_PER_ENTRY);
  localparam logic [16:0] MaxSectors = 17'(MAX_ENTRIES * SECTORS_PER_ENTRY);
  localparam logic [15:0] Spe16 = 16'(SECTORS_PER_ENTRY);
  localparam logic [12:0] FullBytes = 13'((SECTORS_PER_ENTRY * SectorBytes - 1) % 8192);
  localparam logic [63:0] StepBytes = 64'(SECTORS_PER_ENTRY * SectorBytes);
  localparam logic [5:0]  SlotLimit = 6'(SLOT_COUNT);

  logic [5:0]    slots_in_use_q;
  logic          cmd_q;
  logic [47:0]   blk_q;
  logic [15:0]   cnt_q;
  logic [63:0]   addr_q;
  logic [31:0]   busy_q;
  logic          found_q;
  logic          bad_q;
  logic [4:0]    slot_q;
  logic [15:0]   quot_q;
  logic [NW-1:0] n_q;
  logic [RW-1:0] rem_q;
  logic [NW-1:0] idx_q;
  sdcb_res_t     res_q;
  sdcb_res_t     res_d;

  logic [5:0]    limit;
  logic          found;
  logic [4:0]    slot;
  logic [15:0]   cnt_less_one;
  logic [40:0]   product;
  logic [15:0]   rem_full;
  logic [RW+8:0] last_bytes_wide;
  logic [12:0]   entry_bytes;
  logic          final_entry;

  assign status_o.slot_found   = found_q;
  assign status_o.count_bad    = bad_q;
  assign status_o.entries_done = (idx_q == n_q);
  assign res_o                 = res_q;

  // Lowest free slot below the configured limit.
  always_comb begin
    limit = (slots_in_use_q > SlotLimit) ? SlotLimit : slots_in_use_q;
    found = 1'b0;
    slot  = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if ((6'(i) < limit) && !busy_q[i]) begin
        found = 1'b1;
        slot  = 5'(i);
      end
    end
  end

  // Entry count: quotient by reciprocal multiply, remainder from the quotient.
  assign cnt_less_one = cnt_q - 16'd1;
  assign product      = cnt_less_one * Recip;
  assign rem_full     = cnt_less_one - 16'(quot_q * Spe16);

  // Byte count of the current entry; the last one holds the remainder.
  assign final_entry     = (NW'(idx_q + 1'b1) == n_q);
  assign last_bytes_wide = {rem_q, 9'h1ff};
  assign entry_bytes     = final_entry ? 13'(last_bytes_wide) : FullBytes;

  // Configuration register and entry counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_in_use_q <= SlotsInUseReset;
      idx_q          <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        slots_in_use_q <= cfg_wr_data_i;
      end
      if (ctrl_i.capture) begin
        idx_q <= '0;
      end else if (ctrl_i.load && ctrl_i.load_kind == KIND_ENTRY) begin
        idx_q <= NW'(idx_q + 1'b1);
      end
    end
  end

  // Request capture, search and split results, running address.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q  <= command_i;
      blk_q  <= start_block_i;
      cnt_q  <= sector_count_i;
      addr_q <= buffer_address_i;
      busy_q <= busy_slots_i;
    end else if (ctrl_i.load && ctrl_i.load_kind == KIND_ENTRY) begin
      addr_q <= addr_q + StepBytes;
    end
    if (ctrl_i.search) begin
      found_q <= found;
      slot_q  <= slot;
      bad_q   <= (cnt_q == 16'd0) || (17'(cnt_q) > MaxSectors);
      quot_q  <= product[39:24];
    end
    if (ctrl_i.split) begin
      n_q   <= NW'(quot_q + 16'd1);
      rem_q <= RW'(rem_full);
    end
  end

  // Next result: fields that the kind does not use stay zero.
  always_comb begin
    res_d      = '0;
    res_d.kind = ctrl_i.load_kind;
    case (ctrl_i.load_kind)
      KIND_ENTRY: begin
        res_d.slot                 = slot_q;
        res_d.entry_address        = addr_q;
        res_d.entry_bytes_less_one = entry_bytes;
        res_d.entry_total          = 4'(n_q);
      end
      KIND_COMMAND: begin
        res_d.slot            = slot_q;
        res_d.entry_total     = 4'(n_q);
        res_d.ata_opcode      = cmd_q ? OpWriteDmaExt : OpReadDmaExt;
        res_d.fis_block       = blk_q;
        res_d.fis_count       = cnt_q;
        res_d.direction_write = cmd_q;
        res_d.last            = 1'b1;
      end
      default: begin
        res_d.last = 1'b1;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      res_q <= res_d;
    end
  end

endmodule

FILE: src/sata_dma_command_builder.sv
// Top level of the SATA DMA command builder: controller, datapath and channel wiring.
//
//   channel   direction  handshake          payload
//   req_i     in         valid/ready        command, start_block, sector_count,
//                                           buffer_address, busy_slots
//   res_o     out        valid/ready        kind, slot, entry_address, ... last
//   cfg       in         cfg_wr_en_i        cfg_wr_data_i (slots_in_use)
//
// A request is taken in the idle state, then the slot search and entry split states
// follow; results leave one per cycle through the output register unless stalled.
// A stalled result holds in the output register and pauses the sequencer.
// Reset clears the sequencer and sets the slot limit to 32.
module sata_dma_command_builder import sdcb_pkg::*; #(
  parameter int unsigned MAX_ENTRIES       = MaxEntriesDefault,
  parameter int unsigned SECTORS_PER_ENTRY = SectorsPerEntryDefault,
  parameter int unsigned SLOT_COUNT        = SlotCountDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_wr_en_i,
  input  logic [5:0] cfg_wr_data_i,
  sdcb_req_if.sink   req_i,
  sdcb_res_if.source res_o
);

  sdcb_ctrl_t   ctrl;
  sdcb_status_t status;
  sdcb_res_t    res;

  // Sequencer.
  sdcb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  // Datapath.
  sdcb_datapath #(
    .MAX_ENTRIES       (MAX_ENTRIES),
    .SECTORS_PER_ENTRY (SECTORS_PER_ENTRY),
    .SLOT_COUNT        (SLOT_COUNT)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_wr_en_i      (cfg_wr_en_i),
    .cfg_wr_data_i    (cfg_wr_data_i),
    .command_i        (req_i.command),
    .start_block_i    (req_i.start_block),
    .sector_count_i   (req_i.sector_count),
    .buffer_address_i (req_i.buffer_address),
    .busy_slots_i     (req_i.busy_slots),
    .ctrl_i           (ctrl),
    .status_o         (status),
    .res_o            (res)
  );

  // Result payload onto the channel.
  assign res_o.kind                 = res.kind;
  assign res_o.slot                 = res.slot;
  assign res_o.entry_address        = res.entry_address;
  assign res_o.entry_bytes_less_one = res.entry_bytes_less_one;
  assign res_o.entry_total          = res.entry_total;
  assign res_o.ata_opcode           = res.ata_opcode;
  assign res_o.fis_block            = res.fis_block;
  assign res_o.fis_count            = res.fis_count;
  assign res_o.direction_write      = res.direction_write;
  assign res_o.last                 = res.last;

endmodule

FILE: src/sdcb_checker.sv
// Port-level checker for the SATA DMA command builder, bound to the top level.
module sdcb_assertions import sdcb_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [1:0] res_kind_i,
  input logic [4:0] res_slot_i,
  input logic [7:0] res_opcode_i,
  input logic       res_write_i,
  input logic       res_last_i
);

  // A request is taken at most once before the sequencer is busy with it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request channel stayed ready after a request was taken");

  // A waiting result is not withdrawn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result withdrawn while stalled");

  // Error results close the request and carry no slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i == KIND_NO_SLOT || res_kind_i == KIND_BAD_COUNT)
    |-> res_last_i && (res_slot_i == 5'd0) && (res_opcode_i == 8'd0))
    else $error("error result with stray fields");

  // Entries are never final; commands are final with an opcode that matches direction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i == KIND_ENTRY) |-> !res_last_i && (res_opcode_i == 8'd0))
    else $error("transfer entry marked final or with an opcode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i == KIND_COMMAND)
    |-> res_last_i && (res_opcode_i == (res_write_i ? OpWriteDmaExt : OpReadDmaExt)))
    else $error("command result with a wrong opcode or not final");

endmodule

bind sata_dma_command_builder sdcb_assertions u_sdcb_assertions (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_kind_i   (res_o.kind),
  .res_slot_i   (res_o.slot),
  .res_opcode_i (res_o.ata_opcode),
  .res_write_i  (res_o.direction_write),
  .res_last_i   (res_o.last)
);

FILE: verif/sdcb_checker.sv
// Result checker of the SATA DMA command builder: predicts every request and compares results.
`timescale 1ns / 100ps
module sdcb_checker import sdcb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [5:0]  cfg_wr_data_i,
  sdcb_req_if         req_i,
  sdcb_res_if         res_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o,
  output int unsigned checked_o
);

  // Bytes covered by one full transfer entry.
  localparam int unsigned EntryBytes = SectorsPerEntryDefault * SectorBytes;

  logic [5:0]  slot_limit;
  sdcb_res_t   expected_results[$];
  sdcb_res_t   want;
  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned checked_count;

  assign mismatches_o  = mismatch_count;
  assign outstanding_o = outstanding;
  assign checked_o     = checked_count;

  // Work out the results of one request and queue them in arrival order.
  task automatic queue_command_results(input logic cmd, input logic [47:0] lba,
                                       input logic [15:0] sectors,
                                       input logic [63:0] buf_addr,
                                       input logic [31:0] busy);
    int unsigned search_end;
    int unsigned entries;
    int unsigned tail_sectors;
    logic [4:0]  free_slot;
    logic        found;
    logic [63:0] addr;
    sdcb_res_t   res;

    search_end = (slot_limit > SlotCountDefault) ? SlotCountDefault : slot_limit;
    found      = 1'b0;
    free_slot  = '0;
    entries    = 0;
    for (int i = 0; i < search_end; i++) begin
      if (!found && !busy[i]) begin
        found     = 1'b1;
        free_slot = 5'(i);
      end
    end
    if (sectors != 0) begin
      entries = (int'(sectors) - 1) / SectorsPerEntryDefault + 1;
    end

    res      = '0;
    res.last = 1'b1;
    if (!found) begin
      // No slot free within the limit: the count is not looked at.
      res.kind = KIND_NO_SLOT;
      expected_results.push_back(res);
    end else if (sectors == 0 || entries > MaxEntriesDefault) begin
      res.kind = KIND_BAD_COUNT;
      expected_results.push_back(res);
    end else begin
      // One entry per full block of sectors, the remainder in the last one.
      addr = buf_addr;
      for (int e = 0; e < entries; e++) begin
        res               = '0;
        res.kind          = KIND_ENTRY;
        res.slot          = free_slot;
        res.entry_address = addr;
        res.entry_total   = 4'(entries);
        if (e == entries - 1) begin
          tail_sectors = int'(sectors) - (entries - 1) * SectorsPerEntryDefault;
          res.entry_bytes_less_one = 13'(tail_sectors * SectorBytes - 1);
        end else begin
          res.entry_bytes_less_one = 13'(EntryBytes - 1);
        end
        expected_results.push_back(res);
        addr = addr + 64'(EntryBytes);
      end
      res                 = '0;
      res.kind            = KIND_COMMAND;
      res.slot            = free_slot;
      res.entry_total     = 4'(entries);
      res.ata_opcode      = cmd ? OpWriteDmaExt : OpReadDmaExt;
      res.fis_block       = lba;
      res.fis_count       = sectors;
      res.direction_write = cmd;
      res.last            = 1'b1;
      expected_results.push_back(res);
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Track the slot limit, queue predictions and check each result taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_limit     = SlotsInUseReset;
      mismatch_count = 0;
      outstanding    = 0;
      checked_count  = 0;
    end else begin
      if (cfg_wr_en_i) begin
        slot_limit = cfg_wr_data_i;
      end
      if (req_i.valid && req_i.ready) begin
        queue_command_results(req_i.command, req_i.start_block, req_i.sector_count,
                              req_i.buffer_address, req_i.busy_slots);
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_results.size() == 0) begin
          $error("result of kind %0d arrived with nothing outstanding", res_i.kind);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("kind", 64'(want.kind), 64'(res_i.kind));
          compare_field("slot", 64'(want.slot), 64'(res_i.slot));
          compare_field("entry_address", want.entry_address, res_i.entry_address);
          compare_field("entry_bytes_less_one", 64'(want.entry_bytes_less_one),
                        64'(res_i.entry_bytes_less_one));
          compare_field("entry_total", 64'(want.entry_total), 64'(res_i.entry_total));
          compare_field("ata_opcode", 64'(want.ata_opcode), 64'(res_i.ata_opcode));
          compare_field("fis_block", 64'(want.fis_block), 64'(res_i.fis_block));
          compare_field("fis_count", 64'(want.fis_count), 64'(res_i.fis_count));
          compare_field("direction_write", 64'(want.direction_write),
                        64'(res_i.direction_write));
          compare_field("last", 64'(want.last), 64'(res_i.last));
          checked_count++;
        end
      end
      outstanding = expected_results.size();
    end
  end

endmodule

FILE: verif/tb_top.sv
// Testbench top of the SATA DMA command builder: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module tb_top import sdcb_pkg::*;;

  localparam int unsigned PhaseCount = 7;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [5:0] cfg_wr_data;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned requests_sent;
  int unsigned settings_written;
  int unsigned burst_left;
  logic [5:0]  cur_limit;
  bit          hold_off_go;

  sdcb_req_if req_if ();
  sdcb_res_if res_if ();

  sata_dma_command_builder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_wr_en_i   (cfg_wr_en),
    .cfg_wr_data_i (cfg_wr_data),
    .req_i         (req_if),
    .res_o         (res_if)
  );

  sdcb_checker result_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_wr_en_i   (cfg_wr_en),
    .cfg_wr_data_i (cfg_wr_data),
    .req_i         (req_if),
    .res_i         (res_if),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  always #5 clk = ~clk;

  // Offer one request, with a random gap whenever a burst runs out.
  task automatic send_request(input logic cmd, input logic [47:0] lba,
                              input logic [15:0] sectors, input logic [63:0] buf_addr,
                              input logic [31:0] busy);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = $urandom_range(1, 8);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    req_if.command        <= cmd;
    req_if.start_block    <= lba;
    req_if.sector_count   <= sectors;
    req_if.buffer_address <= buf_addr;
    req_if.busy_slots     <= busy;
    req_if.valid          <= 1'b1;
    do @(posedge clk); while (!req_if.ready);
    requests_sent++;
  endtask

  // Mostly well-formed requests with a free slot; the rest hit the error paths.
  task automatic send_random_request();
    logic [47:0] lba;
    logic [15:0] sectors;
    logic [63:0] buf_addr;
    logic [31:0] busy;
    logic [31:0] below;
    int unsigned pick;
    int unsigned eff_limit;
    int unsigned k;

    pick = $urandom_range(0, 99);
    if (pick < 5)       lba = '1;
    else if (pick < 10) lba = '0;
    else                lba = 48'({$urandom(), $urandom()});

    pick = $urandom_range(0, 99);
    if (pick < 65)      sectors = 16'($urandom_range(1, 128));
    else if (pick < 75) sectors = 16'($urandom_range(1, 8) * 16);
    else if (pick < 83) sectors = '0;
    else if (pick < 94) sectors = 16'($urandom_range(129, 65535));
    else if (pick < 97) sectors = 16'd129;
    else                sectors = '1;

    pick = $urandom_range(0, 99);
    if (pick < 6) buf_addr = {48'hFFFF_FFFF_FFFF, 16'($urandom())};
    else          buf_addr = {$urandom(), $urandom()};

    // Keep one slot free inside the searched range most of the time.
    eff_limit = (cur_limit > 32) ? 32 : cur_limit;
    pick      = $urandom_range(0, 99);
    if (pick < 75 && eff_limit > 0) begin
      k     = $urandom_range(0, eff_limit - 1);
      below = (32'h1 << k) - 32'h1;
      busy  = $urandom();
      if ($urandom_range(0, 1)) busy = busy | below;
      busy[k] = 1'b0;
    end else if (pick < 85) begin
      busy = '1;
    end else if (pick < 92) begin
      busy = '0;
    end else begin
      busy = $urandom();
    end
    send_request(1'($urandom_range(0, 1)), lba, sectors, buf_addr, busy);
  endtask

  // Let the block drain, then write a new slot limit.
  task automatic set_slot_limit(input logic [5:0] value);
    req_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_limit = value;
    settings_written++;
  endtask

  // Result receiver: changing stall patterns and one long hold-off.
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    bit          hold_off_done;
    hold_off_done = 1'b0;
    tick = 0;
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_go && !hold_off_done) begin
        hold_off_done = 1'b1;
        repeat (400) begin
          @(posedge clk);
          res_if.ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 80);
      repeat (span) begin
        @(posedge clk);
        tick++;
        case (mode)
          0: begin
            res_if.ready <= 1'b1;
          end
          1: begin
            res_if.ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            res_if.ready <= (tick % 4) != 3;
          end
        endcase
      end
    end
  end

  // Stimulus: directed requests, then random phases under several slot limits.
  initial begin
    logic [5:0]  limits[PhaseCount];
    int unsigned items[PhaseCount];
    limits = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd33, 6'd2, 6'd32};
    items  = '{60, 40, 15, 40, 40, 50, 55};
    limits[5] = 6'($urandom_range(2, 31));
    requests_sent    = 0;
    settings_written = 0;
    burst_left       = 0;
    cur_limit        = SlotsInUseReset;
    hold_off_go      = 1'b0;
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    req_if.valid          <= 1'b0;
    req_if.command        <= 1'b0;
    req_if.start_block    <= '0;
    req_if.sector_count   <= '0;
    req_if.buffer_address <= '0;
    req_if.busy_slots     <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: size boundaries, slot extremes, address wrap and the error order.
    send_request(1'b0, 48'h0, 16'd1, 64'h0, 32'h0);
    send_request(1'b1, 48'hFFFF_FFFF_FFFF, 16'd128, 64'hFFFF_FFFF_FFFF_E000, 32'hFFFF_FFFE);
    send_request(1'b0, 48'h8000_0000_0000, 16'd16, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF);
    send_request(1'b1, 48'h0000_0000_0001, 16'd17, 64'h8000_0000_0000_0000, 32'h0000_FFFF);
    send_request(1'b0, 48'h1234_5678_9ABC, 16'd15, 64'h0000_0000_0000_1000, 32'h0);
    send_request(1'b1, 48'h0FED_CBA9_8765, 16'd127, 64'h0000_0001_0000_0200, 32'h0000_0003);
    send_request(1'b0, 48'h5555_5555_5555, 16'd112, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    send_request(1'b1, 48'hAAAA_AAAA_AAAA, 16'd33, 64'h5555_5555_5555_5555, 32'h5555_5555);
    send_request(1'b0, 48'h0000_0000_0100, 16'd0, 64'h0, 32'h0);
    send_request(1'b1, 48'h0000_0000_0200, 16'd129, 64'h0, 32'h0);
    send_request(1'b0, 48'h0000_0000_0300, 16'hFFFF, 64'h0, 32'h0);
    send_request(1'b1, 48'h0000_0000_0400, 16'd1, 64'h0, 32'hFFFF_FFFF);
    // Busy slots win over a zero count.
    send_request(1'b0, 48'h0000_0000_0500, 16'd0, 64'h0, 32'hFFFF_FFFF);
    send_request(1'b1, 48'hFFFF_FFFF_FFFF, 16'd128, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
    send_request(1'b0, 48'h0, 16'd96, 64'h0000_0000_0000_0001, 32'hFFFF_0000);

    for (int p = 0; p < PhaseCount; p++) begin
      set_slot_limit(limits[p]);
      send_request(1'b0, 48'h0, 16'd1, 64'h0, 32'h7FFF_FFFF);
      send_request(1'b1, 48'h0, 16'd2, 64'h0, 32'h0);
      if (p == 0) begin
        hold_off_go = 1'b1;
      end
      repeat (items[p]) send_random_request();
    end

    // Drain and give the block time to settle.
    req_if.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (20) @(posedge clk);
    $display("Checked %0d results from %0d requests under %0d slot limits.",
             checked, requests_sent, settings_written);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding.", outstanding);
    $display("FAILURE");
    $finish;
  end

endmodule
